// ===== sv/fcbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_pkg
// Shared types and constants of the frustum box/sphere culling block.
// ----------------------------------------------------------------------------
package fcbs_pkg;

  // Number of frustum planes tested side by side
  localparam int NumPlanes = 6;
  // Configuration index width
  localparam int PlaneIdxW = (NumPlanes > 1) ? $clog2(NumPlanes) : 1;

  // Q1.14 value of one, used as w for a sphere query
  localparam logic signed [15:0] Q14One = 16'sd16384;

  // Width of the doubled plane distance and effective radius
  localparam int DistW = 36;

  // Packed plane register: d in the top 16 bits, nx at the bottom
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } plane_t;

  // Result classes
  typedef enum logic [1:0] {
    ClassInside   = 2'd0,
    ClassStraddle = 2'd1,
    ClassOutside  = 2'd2
  } result_class_e;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ===== sv/fcbs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_cfg_regs
// Plane register file; writes with an index past the last plane are dropped.
// ----------------------------------------------------------------------------
module fcbs_cfg_regs import fcbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [PlaneIdxW-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output plane_t               planes_o [NumPlanes]
);

  plane_t planes_q [NumPlanes];
  logic   wr_en;

  // Accept only indexes that name a plane
  assign wr_en = cfg_valid_i && (32'(cfg_index_i) < NumPlanes);

  // Hold plane values, load on a write beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPlanes; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en) begin
      planes_q[cfg_index_i] <= plane_t'(cfg_data_i);
    end
  end

  assign planes_o = planes_q;

endmodule

// ===== sv/fcbs_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_lane
// Three-stage datapath of one plane: products, sums, compares.
// ----------------------------------------------------------------------------
module fcbs_lane import fcbs_pkg::*; (
  input  logic               clk_i,
  input  stage_en_t          en_i,
  input  plane_t             plane_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] center_z_i,
  input  logic signed [15:0] center_w_i,
  input  logic [15:0]        size_x_i,
  input  logic [15:0]        size_y_i,
  input  logic [15:0]        size_z_i,
  input  logic               sphere_s1_i,
  input  logic [15:0]        radius_s1_i,
  input  logic               sphere_s2_i,
  output logic               outside_o,
  output logic               straddle_o
);

  // Stage 1: products
  logic signed [31:0] p_cx_q, p_cy_q, p_cz_q, p_dw_q;
  logic signed [32:0] p_sx_q, p_sy_q, p_sz_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p_cx_q <= plane_i.nx * center_x_i;
      p_cy_q <= plane_i.ny * center_y_i;
      p_cz_q <= plane_i.nz * center_z_i;
      p_dw_q <= plane_i.d * center_w_i;
      p_sx_q <= plane_i.nx * $signed({1'b0, size_x_i});
      p_sy_q <= plane_i.ny * $signed({1'b0, size_y_i});
      p_sz_q <= plane_i.nz * $signed({1'b0, size_z_i});
    end
  end

  // Stage 2: signed distance and effective radius at common scale
  logic signed [33:0]      base;
  logic [32:0]             abs_sx, abs_sy, abs_sz;
  logic [DistW-1:0]        rad_box;
  logic signed [DistW-1:0] dist_d, rad_d, dist_q, rad_q;

  always_comb begin
    base    = 34'(p_cx_q) + 34'(p_cy_q) + 34'(p_cz_q) + 34'(p_dw_q);
    abs_sx  = p_sx_q[32] ? 33'(-p_sx_q) : 33'(p_sx_q);
    abs_sy  = p_sy_q[32] ? 33'(-p_sy_q) : 33'(p_sy_q);
    abs_sz  = p_sz_q[32] ? 33'(-p_sz_q) : 33'(p_sz_q);
    rad_box = DistW'(abs_sx) + DistW'(abs_sy) + DistW'(abs_sz);
    // A box compares twice the distance against the full size sum
    if (sphere_s1_i) begin
      dist_d = DistW'(base);
      rad_d  = $signed(DistW'({radius_s1_i, 14'b0}));
    end else begin
      dist_d = DistW'($signed({base, 1'b0}));
      rad_d  = $signed(rad_box);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      dist_q <= dist_d;
      rad_q  <= rad_d;
    end
  end

  // Stage 3: classify against this plane
  logic outside_q, straddle_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      outside_q  <= (dist_q <= -rad_q);
      straddle_q <= !sphere_s2_i && (dist_q <= rad_q);
    end
  end

  assign outside_o  = outside_q;
  assign straddle_o = straddle_q;

endmodule

// ===== sv/frustum_cull_box_sphere.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_box_sphere
// Culls one box or sphere per beat against the configured frustum planes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one query per beat: kind,
//   center, w, sizes and radius. Output channel (out_valid_o / out_stall_i)
//   returns one beat per query: result_class_o and visible_o, in order.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes plane
//   registers by index; it is always ready, and indexes past the last plane
//   are dropped. Write planes only while no query is in flight.
//   All planes are evaluated in parallel lanes over a four-register pipeline
//   (products, sums, compares, merge); a result is registered in each in turn.
//   One query is taken each cycle unless the pipeline is full and the receiver
//   stalls. Reset clears all planes to zero (a box or a zero-radius sphere is
//   then outside) and empties the pipeline. When the receiver stalls, the
//   output holds its beat; queries keep entering until the pipeline is full,
//   then in_stall_o rises.
// ----------------------------------------------------------------------------
module frustum_cull_box_sphere import fcbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Query channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic signed [15:0]   center_x_i,
  input  logic signed [15:0]   center_y_i,
  input  logic signed [15:0]   center_z_i,
  input  logic signed [15:0]   center_w_i,
  input  logic [15:0]          size_x_i,
  input  logic [15:0]          size_y_i,
  input  logic [15:0]          size_z_i,
  input  logic [15:0]          radius_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           result_class_o,
  output logic                 visible_o,
  // Configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [PlaneIdxW-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  plane_t    planes [NumPlanes];
  stage_en_t en;
  logic      en4;
  logic      v1_q, v2_q, v3_q, v4_q;

  assign cfg_ready_o = 1'b1;

  fcbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  // Advance a stage when it is empty or the next one advances
  assign en4  = !v4_q || !out_stall_i;
  assign en.s3 = !v3_q || en4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;
  assign in_stall_o = !en.s1;

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en4)   v4_q <= v3_q;
    end
  end

  // Carry query kind and radius alongside the lanes
  logic               sphere_s1_q, sphere_s2_q;
  logic [15:0]        radius_s1_q;
  logic signed [15:0] w_eff;

  assign w_eff = kind_i ? Q14One : center_w_i;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      sphere_s1_q <= kind_i;
      radius_s1_q <= radius_i;
    end
    if (en.s2) begin
      sphere_s2_q <= sphere_s1_q;
    end
  end

  // One lane per plane
  logic [NumPlanes-1:0] outside, straddle;

  for (genvar g = 0; g < NumPlanes; g++) begin : g_lane
    fcbs_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .plane_i     (planes[g]),
      .center_x_i  (center_x_i),
      .center_y_i  (center_y_i),
      .center_z_i  (center_z_i),
      .center_w_i  (w_eff),
      .size_x_i    (size_x_i),
      .size_y_i    (size_y_i),
      .size_z_i    (size_z_i),
      .sphere_s1_i (sphere_s1_q),
      .radius_s1_i (radius_s1_q),
      .sphere_s2_i (sphere_s2_q),
      .outside_o   (outside[g]),
      .straddle_o  (straddle[g])
    );
  end

  // Merge: any outside plane wins, then any straddle
  result_class_e class_d, class_q;

  always_comb begin
    priority if (|outside) begin
      class_d = ClassOutside;
    end else if (|straddle) begin
      class_d = ClassStraddle;
    end else begin
      class_d = ClassInside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o    = v4_q;
  assign result_class_o = class_q;
  assign visible_o      = (class_q != ClassOutside);

  // Checks
  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_class_o == ClassInside || result_class_o == ClassStraddle ||
                     result_class_o == ClassOutside))
    else $error("result class code out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled while pipeline has a free slot");

  a_stage3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4) |=> out_valid_o)
    else $error("beat lost between compare stage and output");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_class_o)))
    else $error("stalled result changed");

endmodule

// ===== tb/sv/fcbs_cull_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_cull_check_pkg
// Query beat type and the expected-class tracker for the culling testbench.
// ----------------------------------------------------------------------------
package fcbs_cull_check_pkg;
  import fcbs_pkg::*;

  // One query beat, field for field as on the input ports
  typedef struct packed {
    logic               kind;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [15:0] cw;
    logic [15:0]        sx;
    logic [15:0]        sy;
    logic [15:0]        sz;
    logic [15:0]        radius;
  } cull_query_t;

  class cull_scoreboard;
    plane_t        planes[NumPlanes];
    result_class_e expected_class_q[$];
    int unsigned   error_count;

    function new();
      foreach (planes[i]) planes[i] = '0;
      error_count = 0;
    endfunction

    // Mirror a plane write; indexes past the last plane are dropped
    function void write_plane(logic [PlaneIdxW-1:0] index, logic [63:0] data);
      if (index < NumPlanes) planes[index] = data;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Classify a query: scan planes upward, first outside plane wins
    function result_class_e classify(cull_query_t q);
      longint nx, ny, nz, d, base, dist2, rad2;
      result_class_e cls;
      cls = ClassInside;
      for (int i = 0; i < NumPlanes && cls != ClassOutside; i++) begin
        nx = longint'(planes[i].nx);
        ny = longint'(planes[i].ny);
        nz = longint'(planes[i].nz);
        d  = longint'(planes[i].d);
        base = nx * longint'(q.cx) + ny * longint'(q.cy) + nz * longint'(q.cz);
        if (q.kind) begin
          // Sphere: w is one, compare against the radius at Q.14 scale
          if (base + d * longint'(Q14One) <= -(longint'(q.radius) * longint'(Q14One)))
            cls = ClassOutside;
        end else begin
          // Box: doubled distance against the full projected extent
          dist2 = 2 * (base + d * longint'(q.cw));
          rad2  = magnitude(nx * longint'(q.sx)) + magnitude(ny * longint'(q.sy)) +
                  magnitude(nz * longint'(q.sz));
          if (dist2 <= -rad2) cls = ClassOutside;
          else if (dist2 <= rad2) cls = ClassStraddle;
        end
      end
      return cls;
    endfunction

    function void note_query(cull_query_t q);
      expected_class_q.push_back(classify(q));
    endfunction

    function void check_result(logic [1:0] result_class, logic visible);
      result_class_e exp_class;
      logic          exp_visible;
      if (expected_class_q.size() == 0) begin
        $error("result beat with nothing pending: result_class %0d visible %0d",
               result_class, visible);
        error_count++;
        return;
      end
      exp_class   = expected_class_q.pop_front();
      exp_visible = (exp_class != ClassOutside);
      if (result_class !== exp_class) begin
        $error("result_class mismatch: expected %0d, actual %0d", exp_class, result_class);
        error_count++;
      end
      if (visible !== exp_visible) begin
        $error("visible mismatch: expected %0d, actual %0d", exp_visible, visible);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_class_q.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/frustum_cull_box_sphere_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_box_sphere_tb
// Drives box and sphere queries through the culling block under several plane
// sets, with random gaps and output stalls, and checks every result beat.
// ----------------------------------------------------------------------------
module frustum_cull_box_sphere_tb;
  import fcbs_pkg::*;
  import fcbs_cull_check_pkg::*;

  localparam int PhaseItems   = 75;
  localparam int SettleCycles = 8;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cull_query_t          drv_query;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           result_class;
  logic                 visible;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PlaneIdxW-1:0] cfg_index;
  logic [63:0]          cfg_data;

  cull_scoreboard sb;

  frustum_cull_box_sphere uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (drv_query.kind),
    .center_x_i     (drv_query.cx),
    .center_y_i     (drv_query.cy),
    .center_z_i     (drv_query.cz),
    .center_w_i     (drv_query.cw),
    .size_x_i       (drv_query.sx),
    .size_y_i       (drv_query.sy),
    .size_z_i       (drv_query.sz),
    .radius_i       (drv_query.radius),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_class_o (result_class),
    .visible_o      (visible),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  // Track accepted beats on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_query(drv_query);
      if (out_valid && !out_stall) sb.check_result(result_class, visible);
      if (cfg_valid && cfg_ready) sb.write_plane(cfg_index, cfg_data);
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Random query: mostly near the frustum at the given span, some fully random
  function automatic cull_query_t make_query(int span);
    cull_query_t q;
    q.kind = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 3) begin
      q.cx = 16'($urandom);
      q.cy = 16'($urandom);
      q.cz = 16'($urandom);
      q.cw = 16'($urandom);
      q.sx = 16'($urandom);
      q.sy = 16'($urandom);
      q.sz = 16'($urandom);
      q.radius = 16'($urandom);
    end else begin
      q.cx = 16'(int'($urandom_range(0, 2 * span)) - span);
      q.cy = 16'(int'($urandom_range(0, 2 * span)) - span);
      q.cz = 16'(int'($urandom_range(0, 2 * span)) - span);
      q.cw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : Q14One;
      q.sx = 16'($urandom_range(0, span));
      q.sy = 16'($urandom_range(0, span));
      q.sz = 16'($urandom_range(0, span));
      // Uniform box now and then
      if ($urandom_range(0, 4) == 0) begin
        q.sy = q.sx;
        q.sz = q.sx;
      end
      q.radius = 16'($urandom_range(0, span));
    end
    return q;
  endfunction

  // Hold the beat until accepted, then idle for the given number of cycles
  task automatic send_query(cull_query_t q, int gap);
    @(negedge clk);
    in_valid  <= 1'b1;
    drv_query <= q;
    do @(posedge clk); while (in_stall);
    repeat (gap) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      drv_query <= make_query(16000);
    end
  endtask

  task automatic send_shape(bit kind, int cx, int cy, int cz, int cw,
                            int sx, int sy, int sz, int r);
    cull_query_t q;
    q.kind = kind;
    q.cx = 16'(cx);
    q.cy = 16'(cy);
    q.cz = 16'(cz);
    q.cw = 16'(cw);
    q.sx = 16'(sx);
    q.sy = 16'(sy);
    q.sz = 16'(sz);
    q.radius = 16'(r);
    send_query(q, $urandom_range(0, 1));
  endtask

  task automatic cfg_write(logic [PlaneIdxW-1:0] index, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Opposing plane pairs around the origin, or random bits when wild
  task automatic program_planes(int span, bit wild);
    plane_t p;
    p = '0;
    for (int i = 0; i < NumPlanes; i++) begin
      if (wild) begin
        p = {$urandom, $urandom};
      end else begin
        if (i % 2 == 0) begin
          p.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
          p.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
          p.nz = 16'(int'($urandom_range(0, 32768)) - 16384);
        end else begin
          p.nx = -p.nx;
          p.ny = -p.ny;
          p.nz = -p.nz;
        end
        p.d = 16'($urandom_range(span / 2, span));
      end
      cfg_write(PlaneIdxW'(i), p);
    end
  endtask

  // Receiver stalls: calm stretches alternate with random stalling
  initial begin
    int stall_left;
    int calm_left;
    bit calm;
    stall_left = 0;
    calm_left  = 0;
    calm       = 1'b0;
    out_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(20, 120);
      end
      calm_left--;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_len();
      end
    end
  end

  // Stimulus
  initial begin
    plane_t          p;
    logic [63:0]     extremes[3];
    int              spans[6];
    int              in_calm_left;
    bit              in_calm;
    sb = new();
    extremes = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF};
    spans = '{64, 1000, 8000, 16000, 2000, 300};
    in_calm_left = 0;
    in_calm = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    drv_query = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Planes still zero after reset: a box is outside, a sphere with a radius is inside
    send_shape(0, 5, -7, 9, 16384, 3, 3, 3, 0);
    send_shape(1, 0, 0, 0, 0, 0, 0, 0, 65535);
    wait_idle();

    // Axis-aligned cube of half width 1000
    for (int i = 0; i < NumPlanes; i++) begin
      p = '0;
      case (i / 2)
        0: p.nx = 16'((i % 2) ? -16384 : 16384);
        1: p.ny = 16'((i % 2) ? -16384 : 16384);
        default: p.nz = 16'((i % 2) ? -16384 : 16384);
      endcase
      p.d = 1000;
      cfg_write(PlaneIdxW'(i), p);
    end
    // Writes past the last plane must not alias onto a real one
    for (int i = NumPlanes; i < (1 << PlaneIdxW); i++) cfg_write(PlaneIdxW'(i), '0);

    send_shape(0, 0, 0, 0, 16384, 10, 10, 10, 777);
    // Box touching minus the radius is outside, one step wider straddles
    send_shape(0, -1100, 0, 0, 16384, 200, 0, 0, 5);
    send_shape(0, -1100, 0, 0, 16384, 202, 0, 0, 5);
    // Box touching plus the radius straddles, one step narrower is inside
    send_shape(0, -900, 0, 0, 16384, 200, 0, 0, 5);
    send_shape(0, -900, 0, 0, 16384, 198, 0, 0, 5);
    // Uniform box exactly at the straddle limit
    send_shape(0, 0, 0, 0, 16384, 2000, 2000, 2000, 0);
    // Straddle on an early plane, outside on a later one
    send_shape(0, -900, 0, -5000, 16384, 200, 0, 0, 0);
    // Zero and negative w
    send_shape(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_shape(0, 0, 0, 0, -16384, 0, 0, 0, 0);
    // Sphere touching the plane is outside, one unit larger is visible
    send_shape(1, -1100, 0, 0, -3, 400, 400, 400, 100);
    send_shape(1, -1100, 0, 0, 12, 0, 9, 0, 101);
    send_shape(1, 0, 0, 0, 0, 65535, 65535, 65535, 0);
    send_shape(1, 0, 30000, 0, 16384, 1, 2, 3, 5);
    wait_idle();

    // Extreme plane coefficients with extreme query fields
    foreach (extremes[e]) begin
      for (int i = 0; i < NumPlanes; i++) cfg_write(PlaneIdxW'(i), extremes[e]);
      send_shape(0, -32768, -32768, -32768, -32768, 65535, 65535, 65535, 0);
      send_shape(0, 32767, 32767, 32767, 32767, 0, 0, 0, 65535);
      send_shape(1, -32768, 32767, -32768, 0, 0, 0, 0, 65535);
      wait_idle();
    end

    // Random phases, each under a new plane set
    foreach (spans[ph]) begin
      program_planes(spans[ph], ph == 4);
      for (int n = 0; n < PhaseItems; n++) begin
        if (in_calm_left == 0) begin
          in_calm      = ($urandom_range(0, 2) == 0);
          in_calm_left = $urandom_range(10, 60);
        end
        in_calm_left--;
        send_query(make_query(spans[ph]),
                   (in_calm || $urandom_range(0, 1)) ? 0 : pick_len());
      end
      wait_idle();
    end

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("frustum_cull_box_sphere regression: pass");
    end else begin
      $display("frustum_cull_box_sphere regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("frustum_cull_box_sphere regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fcbs_pkg.sv
sv/fcbs_cfg_regs.sv
sv/fcbs_lane.sv
sv/frustum_cull_box_sphere.sv
tb/sv/fcbs_cull_check_pkg.sv
tb/sv/frustum_cull_box_sphere_tb.sv
